### src/prqs_pkg.sv
// Shared types, constants and codes of the priority ready-queue scheduler.
package prqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int LEVEL_BITS  = 4;
  localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_CREATE    = 2'd0,
    FUNC_YIELD     = 2'd1,
    FUNC_TERMINATE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REINS,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]            func;
    logic [ID_BITS-1:0]    new_thread_id;
    logic [LEVEL_BITS-1:0] new_priority;
  } item_t;

  typedef struct packed {
    logic                  running_valid;
    logic [ID_BITS-1:0]    running_thread;
    logic [LEVEL_BITS-1:0] running_level;
    logic [FILL_BITS-1:0]  ready_count;
    logic                  dropped;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic pop;
    logic ins_new;
    logic ins_hold;
    logic clr_run;
    logic set_drop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] func;
    logic       empty;
    logic       full;
    logic       hold_present;
  } status_t;

endpackage

### src/priority_ready_queue_scheduler.sv
// Top level of the priority ready-queue scheduler.
//
// The scheduler keeps one running-thread slot and a ready queue of up to
// sixteen threads sorted by priority; a lower level is served first and equal
// levels leave in arrival order.  An item is taken on item_i at a rising edge
// where start is high and busy is low.  Its func field selects create, yield
// or terminate; the unused code leaves the state as it is.
// Each item produces exactly one result on result_o, marked by done_o for a
// single cycle.  The receiver cannot hold a result off, so it must sample it
// in that cycle.
// The accepting edge leads to the execute step and from there to the respond
// step, where done_o rises; a yield with a nonempty queue passes through a
// reinsert step of its own between them, where the former running thread is
// reinserted.  Busy stays high until the done cycle ends, so the block takes
// no new item before the last is through; the controller's step sequence sets
// how long one item occupies the block, as all entries do each shift at once.
// A create into a full queue is discarded and the result shows dropped high.
// After reset the queue is empty and thread zero runs at priority one; queue
// entries are not cleared because only entries below the fill count are read.
module priority_ready_queue_scheduler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  prqs_pkg::item_t   item_i,
  output logic              busy,
  output logic              done_o,
  output prqs_pkg::result_t result_o
);

  prqs_pkg::cmd_t    cmd;
  prqs_pkg::status_t status;

  prqs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  prqs_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

### src/prqs_dp.sv
// Datapath of the scheduler: running slot, sorted ready queue and item register.
module prqs_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  prqs_pkg::item_t  item_i,
  input  prqs_pkg::cmd_t   cmd_i,
  output prqs_pkg::status_t status_o,
  output prqs_pkg::result_t result_o
);

  localparam int D  = prqs_pkg::QUEUE_DEPTH;
  localparam int IB = prqs_pkg::ID_BITS;
  localparam int LB = prqs_pkg::LEVEL_BITS;
  localparam int FB = prqs_pkg::FILL_BITS;

  prqs_pkg::item_t item_q;

  logic [IB-1:0] qid_q [D];
  logic [LB-1:0] qlvl_q[D];
  logic [IB-1:0] qid_d [D];
  logic [LB-1:0] qlvl_d[D];

  logic [FB-1:0] fill_q, fill_d;
  logic [IB-1:0] run_id_q, run_id_d;
  logic [LB-1:0] run_lvl_q, run_lvl_d;
  logic          run_present_q, run_present_d;
  logic          drop_q, drop_d;

  logic [IB-1:0] hold_id_q;
  logic [LB-1:0] hold_lvl_q;
  logic          hold_present_q;

  logic [IB-1:0] ins_id;
  logic [LB-1:0] ins_lvl;
  logic          ins;
  logic [D-1:0]  le;
  logic [D-1:0]  le_prev;

  always_comb begin
    ins     = cmd_i.ins_new | cmd_i.ins_hold;
    ins_id  = cmd_i.ins_hold ? hold_id_q  : item_q.new_thread_id;
    ins_lvl = cmd_i.ins_hold ? hold_lvl_q : item_q.new_priority;

    // Sorted queue: entries that stay ahead of the new one form a prefix.
    for (int k = 0; k < D; k++) begin
      le[k] = (FB'(k) < fill_q) && (qlvl_q[k] <= ins_lvl);
    end
    le_prev[0] = 1'b1;
    for (int k = 1; k < D; k++) begin
      le_prev[k] = le[k-1];
    end

    for (int k = 0; k < D; k++) begin
      qid_d[k]  = qid_q[k];
      qlvl_d[k] = qlvl_q[k];
    end

    if (cmd_i.pop) begin
      for (int k = 0; k < D - 1; k++) begin
        qid_d[k]  = qid_q[k+1];
        qlvl_d[k] = qlvl_q[k+1];
      end
    end else if (ins) begin
      if (!le[0]) begin
        qid_d[0]  = ins_id;
        qlvl_d[0] = ins_lvl;
      end
      for (int k = 1; k < D; k++) begin
        if (!le_prev[k]) begin
          qid_d[k]  = qid_q[k-1];
          qlvl_d[k] = qlvl_q[k-1];
        end else if (!le[k]) begin
          qid_d[k]  = ins_id;
          qlvl_d[k] = ins_lvl;
        end
      end
    end

    fill_d = fill_q;
    if (cmd_i.pop) begin
      fill_d = fill_q - FB'(1);
    end else if (ins) begin
      fill_d = fill_q + FB'(1);
    end

    run_id_d      = run_id_q;
    run_lvl_d     = run_lvl_q;
    run_present_d = run_present_q;
    if (cmd_i.pop) begin
      run_id_d      = qid_q[0];
      run_lvl_d     = qlvl_q[0];
      run_present_d = 1'b1;
    end else if (cmd_i.clr_run) begin
      run_id_d      = '0;
      run_lvl_d     = '0;
      run_present_d = 1'b0;
    end

    drop_d = drop_q;
    if (cmd_i.load) begin
      drop_d = 1'b0;
    end else if (cmd_i.set_drop) begin
      drop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q        <= '0;
      run_id_q      <= '0;
      run_lvl_q     <= LB'(1);
      run_present_q <= 1'b1;
      drop_q        <= 1'b0;
    end else begin
      fill_q        <= fill_d;
      run_id_q      <= run_id_d;
      run_lvl_q     <= run_lvl_d;
      run_present_q <= run_present_d;
      drop_q        <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < D; k++) begin
      qid_q[k]  <= qid_d[k];
      qlvl_q[k] <= qlvl_d[k];
    end
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.pop) begin
      hold_id_q      <= run_id_q;
      hold_lvl_q     <= run_lvl_q;
      hold_present_q <= run_present_q;
    end
  end

  assign status_o.func         = item_q.func;
  assign status_o.empty        = (fill_q == '0);
  assign status_o.full         = (fill_q == FB'(D));
  assign status_o.hold_present = hold_present_q;

  assign result_o.running_valid  = run_present_q;
  assign result_o.running_thread = run_present_q ? run_id_q : '0;
  assign result_o.running_level  = run_present_q ? run_lvl_q : '0;
  assign result_o.ready_count    = fill_q;
  assign result_o.dropped        = drop_q;

endmodule

### src/prqs_ctrl.sv
// Controller state machine that sequences one scheduler operation.
module prqs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  prqs_pkg::status_t status_i,
  output prqs_pkg::cmd_t    cmd_o,
  output logic              busy,
  output logic              done_o
);

  prqs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prqs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      prqs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = prqs_pkg::ST_EXEC;
        end
      end
      prqs_pkg::ST_EXEC: begin
        state_d = prqs_pkg::ST_RESP;
        case (status_i.func)
          prqs_pkg::FUNC_CREATE: begin
            if (status_i.full) begin
              cmd_o.set_drop = 1'b1;
            end else begin
              cmd_o.ins_new = 1'b1;
            end
          end
          prqs_pkg::FUNC_YIELD: begin
            if (!status_i.empty) begin
              cmd_o.pop = 1'b1;
              state_d   = prqs_pkg::ST_REINS;
            end
          end
          prqs_pkg::FUNC_TERMINATE: begin
            if (status_i.empty) begin
              cmd_o.clr_run = 1'b1;
            end else begin
              cmd_o.pop = 1'b1;
            end
          end
          default: ;
        endcase
      end
      prqs_pkg::ST_REINS: begin
        // The pop just freed a slot, so the former running thread always fits.
        cmd_o.ins_hold = status_i.hold_present;
        state_d        = prqs_pkg::ST_RESP;
      end
      prqs_pkg::ST_RESP: begin
        done_o  = 1'b1;
        state_d = prqs_pkg::ST_IDLE;
      end
      default: state_d = prqs_pkg::ST_IDLE;
    endcase
  end

endmodule
